// ===== rtl/tlpq_pkg.sv =====
`timescale 1ns / 1ps

package tlpq_pkg;

    // Width of the payload field on the result channel.
    localparam int OUT_PAYLOAD_BITS = 32;

    // Number of priority levels; level n is held in store bank n-1.
    localparam int LEVELS = 3;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_PRIO = 2'd3
    } status_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_op_t;

    typedef struct packed {
        status_t    status;
        logic [1:0] level;
        logic       now_empty;
        logic       deq_ok;
    } result_t;

endpackage

// ===== rtl/three_level_priority_queue.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports
// s_        in         s_valid, s_ready, s_kind, s_priority_req, s_payload
// m_        out        m_valid, m_ready, m_out_payload, m_out_priority, m_now_empty,
//                      m_status
//
// One item per cycle sustained while m_ready is high. The s_ transfer loads
// the input register; the item then loads the result register and store read
// register, and m_valid rises with them, so the m_ transfer follows both loads.
// The rate is set by the single-port payload store: an item does at most one
// write or one read. Reset clears the level pointers and counts; entries
// outside a level's live range are never read, so the store needs no clearing.
// When m_ready is low the result holds, the input register keeps one item and
// s_ready then drops until the result transfer frees the output stage.

module three_level_priority_queue #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [1:0]                          s_priority_req,
    input  logic [PAYLOAD_BITS-1:0]             s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tlpq_pkg::OUT_PAYLOAD_BITS-1:0] m_out_payload,
    output logic [1:0]                          m_out_priority,
    output logic                                m_now_empty,
    output logic [1:0]                          m_status
);
    import tlpq_pkg::*;

    localparam int IDX_BITS  = $clog2(QUEUE_DEPTH);
    localparam int ADDR_BITS = IDX_BITS + 2;
    localparam int WORDS     = LEVELS << IDX_BITS;

    logic                    in_valid_reg;
    logic                    in_kind_reg;
    logic [1:0]              in_prio_reg;
    logic [PAYLOAD_BITS-1:0] in_payload_reg;
    logic                    out_valid_reg;
    result_t                 res_reg;

    logic                    item_go;
    mem_op_t                 mem_op;
    logic [ADDR_BITS-1:0]    mem_addr;
    result_t                 result;
    logic [PAYLOAD_BITS-1:0] rd_data;
    logic [PAYLOAD_BITS+OUT_PAYLOAD_BITS-1:0] pay_wide;

    // The item in the input register is worked on when the result stage is
    // free or is being emptied in the same cycle.
    assign item_go = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || item_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (item_go) begin
                in_valid_reg <= 1'b0;
            end
            if (item_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg    <= s_kind;
            in_prio_reg    <= s_priority_req;
            in_payload_reg <= s_payload;
        end
        if (item_go) begin
            res_reg <= result;
        end
    end

    tlpq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_BITS    (IDX_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (item_go),
        .kind     (in_kind_reg),
        .prio     (in_prio_reg),
        .mem_op   (mem_op),
        .mem_addr (mem_addr),
        .result   (result)
    );

    tlpq_store #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (PAYLOAD_BITS),
        .WORDS     (WORDS)
    ) u_store (
        .aclk    (aclk),
        .mem_op  (mem_op),
        .addr    (mem_addr),
        .wr_data (in_payload_reg),
        .rd_data (rd_data)
    );

    // The store read register only loads on a successful dequeue, so it
    // holds steady while the result waits.
    assign pay_wide       = {{OUT_PAYLOAD_BITS{1'b0}}, rd_data};
    assign m_valid        = out_valid_reg;
    assign m_out_payload  = res_reg.deq_ok ? pay_wide[OUT_PAYLOAD_BITS-1:0] : '0;
    assign m_out_priority = res_reg.level;
    assign m_now_empty    = res_reg.now_empty;
    assign m_status       = res_reg.status;

    a_empty_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_now_empty)
        else $error("dequeue on empty reported a nonempty queue");

    a_full_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> !m_now_empty)
        else $error("full store reported as empty");

    a_fail_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_out_priority == 2'd0 && m_out_payload == '0)
        else $error("failed item returned data");

    a_bad_prio : assert property (@(posedge aclk) disable iff (!aresetn)
        item_go && in_kind_reg == KIND_ENQ && in_prio_reg == 2'd0
        |=> m_valid && m_status == ST_BAD_PRIO)
        else $error("enqueue at level zero not flagged");

endmodule

// ===== rtl/tlpq_store.sv =====
`timescale 1ns / 1ps

module tlpq_store #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 32,
    parameter int WORDS     = 192
) (
    input  logic                   aclk,
    input  tlpq_pkg::mem_op_t      mem_op,
    input  logic [ADDR_BITS-1:0]   addr,
    input  logic [DATA_BITS-1:0]   wr_data,
    output logic [DATA_BITS-1:0]   rd_data
);
    import tlpq_pkg::*;

    logic [DATA_BITS-1:0] mem_reg [0:WORDS-1];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_op.wr_en) begin
            mem_reg[addr] <= wr_data;
        end
        if (mem_op.rd_en) begin
            rd_data_reg <= mem_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tlpq_ctrl.sv =====
`timescale 1ns / 1ps

module tlpq_ctrl #(
    parameter int QUEUE_DEPTH = 64,
    parameter int IDX_BITS    = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  logic                  kind,
    input  logic [1:0]            prio,
    output tlpq_pkg::mem_op_t     mem_op,
    output logic [IDX_BITS+1:0]   mem_addr,
    output tlpq_pkg::result_t     result
);
    import tlpq_pkg::*;

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Each level is a circular FIFO in its own bank of the store; the total
    // count caps the sum of all levels at the queue depth.
    logic [IDX_BITS-1:0] head_reg  [LEVELS];
    logic [IDX_BITS-1:0] head_next [LEVELS];
    logic [IDX_BITS-1:0] tail_reg  [LEVELS];
    logic [IDX_BITS-1:0] tail_next [LEVELS];
    logic [CNT_BITS-1:0] cnt_reg   [LEVELS];
    logic [CNT_BITS-1:0] cnt_next  [LEVELS];
    logic [CNT_BITS-1:0] total_reg;
    logic [CNT_BITS-1:0] total_next;

    logic [1:0] enq_idx;
    logic [1:0] deq_idx;

    function automatic logic [IDX_BITS-1:0] ptr_inc(input logic [IDX_BITS-1:0] p);
        logic [IDX_BITS-1:0] r;
        if (p == IDX_BITS'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + IDX_BITS'(1);
        end
        return r;
    endfunction

    assign enq_idx = (prio == 2'd0) ? 2'd0 : prio - 2'd1;

    // Strict priority: the highest level that holds an entry is served.
    always_comb begin
        if (cnt_reg[2] != '0) begin
            deq_idx = 2'd2;
        end else if (cnt_reg[1] != '0) begin
            deq_idx = 2'd1;
        end else begin
            deq_idx = 2'd0;
        end
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        mem_op     = '0;
        mem_addr   = '0;
        result     = '0;
        result.status = ST_OK;
        if (kind == KIND_ENQ) begin
            if (prio == 2'd0) begin
                result.status = ST_BAD_PRIO;
            end else if (total_reg == CNT_BITS'(QUEUE_DEPTH)) begin
                result.status = ST_FULL;
            end else begin
                mem_op.wr_en       = fire;
                mem_addr           = {enq_idx, tail_reg[enq_idx]};
                tail_next[enq_idx] = ptr_inc(tail_reg[enq_idx]);
                cnt_next[enq_idx]  = cnt_reg[enq_idx] + CNT_BITS'(1);
                total_next         = total_reg + CNT_BITS'(1);
            end
        end else begin
            if (total_reg == '0) begin
                result.status = ST_EMPTY;
            end else begin
                mem_op.rd_en       = fire;
                mem_addr           = {deq_idx, head_reg[deq_idx]};
                head_next[deq_idx] = ptr_inc(head_reg[deq_idx]);
                cnt_next[deq_idx]  = cnt_reg[deq_idx] - CNT_BITS'(1);
                total_next         = total_reg - CNT_BITS'(1);
                result.level       = deq_idx + 2'd1;
                result.deq_ok      = 1'b1;
            end
        end
        result.now_empty = (total_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            total_reg <= '0;
        end else if (fire) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
        end
    end

endmodule
